### src/clle_pkg.sv
// Package with request codes and shared types of the cursor linked-list engine.
`timescale 1ns / 1ps
package clle_pkg;
  localparam int ReqBits = 3;
  localparam logic [ReqBits-1:0] ReqInsert  = 3'd0;
  localparam logic [ReqBits-1:0] ReqRemove  = 3'd1;
  localparam logic [ReqBits-1:0] ReqRewind  = 3'd2;
  localparam logic [ReqBits-1:0] ReqAdvance = 3'd3;
  localparam logic [ReqBits-1:0] ReqRead    = 3'd4;
  localparam int InValueBits = 32;
  localparam int OutValueBits = 32;
  localparam int SizeBits = 7;
endpackage

### src/cursor_linked_list_engine_core.sv
// Top level of the cursor linked-list engine with a sequenced link memory.
//   channel | valid        | stall        | payload
//   request | req_valid_i  | req_stall_o  | req_type_i, item_value_i
//   result  | res_valid_o  | res_stall_i  | value_out_o, at_end_o, ok_o, empty_res_o,
//           |              |              | full_res_o, size_o
// A request holds the engine from its accepting cycle until its result is taken.
// The sequence is set by one access per link memory per cycle.
// Cursor moves, read and refused requests pass RdA, Fin, FinV and Out; insert adds WrA, WrB;
// remove adds RmP, RmN, RmL, MvN, and MvV, MvP when a slot is moved (MvV again on a refresh).
// Reset clears head, tail, cursor, count and control; the slot memories hold no reset.
// While a result waits under stall no new request is taken.
`timescale 1ns / 1ps
module cursor_linked_list_engine_core
  import clle_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  output logic                    req_stall_o,
  input  logic [ReqBits-1:0]      req_type_i,
  input  logic [InValueBits-1:0]  item_value_i,
  output logic                    res_valid_o,
  input  logic                    res_stall_i,
  output logic [OutValueBits-1:0] value_out_o,
  output logic                    at_end_o,
  output logic                    ok_o,
  output logic                    empty_res_o,
  output logic                    full_res_o,
  output logic [SizeBits-1:0]     size_o
);
  localparam int IW = $clog2(CAPACITY);
  localparam int LW = IW + 1;
  localparam logic [LW-1:0] Nil = LW'(CAPACITY);

  typedef enum logic [12:0] {
    StIdle  = 13'b0000000000001,
    StRdA   = 13'b0000000000010,
    StWrA   = 13'b0000000000100,
    StWrB   = 13'b0000000001000,
    StRmP   = 13'b0000000010000,
    StRmN   = 13'b0000000100000,
    StRmL   = 13'b0000001000000,
    StMvV   = 13'b0000010000000,
    StMvP   = 13'b0000100000000,
    StMvN   = 13'b0001000000000,
    StFin   = 13'b0010000000000,
    StFinV  = 13'b0100000000000,
    StOut   = 13'b1000000000000
  } state_e;

  logic [LW-1:0] nxt_m [CAPACITY];
  logic [LW-1:0] prv_m [CAPACITY];
  logic [VALUE_BITS-1:0] val_m [CAPACITY];

  state_e st_q;
  logic [LW-1:0] head_q, tail_q, cur_q, cnt_q;
  logic [ReqBits-1:0] req_q;
  logic [VALUE_BITS-1:0] ival_q, rval_q;
  logic [LW-1:0] d_q, p_q, n_q, lp_q, ln_q;
  logic ok_q;

  logic [LW-1:0] last;
  assign last = cnt_q - LW'(1);

  assign req_stall_o = (st_q != StIdle);
  assign res_valid_o = (st_q == StOut);
  assign at_end_o = (cur_q == Nil);
  assign value_out_o = at_end_o ? '0 : OutValueBits'(rval_q);
  assign ok_o = ok_q;
  assign empty_res_o = (cnt_q == '0);
  assign full_res_o = (cnt_q == Nil);
  assign size_o = SizeBits'(cnt_q);

  // Memory writes and reads, one slot per cycle in each array.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StWrA: begin
        if (req_q == ReqInsert) begin
          val_m[cnt_q[IW-1:0]] <= ival_q;
          nxt_m[cnt_q[IW-1:0]] <= (cur_q == Nil) ? Nil : cur_q;
          prv_m[cnt_q[IW-1:0]] <= p_q;
        end
      end
      StWrB: begin
        if (p_q != Nil) nxt_m[p_q[IW-1:0]] <= cnt_q;
        if (cur_q != Nil) prv_m[cur_q[IW-1:0]] <= cnt_q;
      end
      StRmL: begin
        if (p_q != Nil) nxt_m[p_q[IW-1:0]] <= n_q;
        if (n_q != Nil) prv_m[n_q[IW-1:0]] <= p_q;
      end
      StMvV: begin
        val_m[d_q[IW-1:0]] <= rval_q;
        prv_m[d_q[IW-1:0]] <= lp_q;
        nxt_m[d_q[IW-1:0]] <= ln_q;
      end
      StMvP: begin
        if (lp_q != Nil) nxt_m[lp_q[IW-1:0]] <= d_q;
        if (ln_q != Nil) prv_m[ln_q[IW-1:0]] <= d_q;
      end
      default: ;
    endcase
    if (st_q == StRmL) rval_q <= val_m[last[IW-1:0]];
    else if (st_q == StFinV && cur_q != Nil) rval_q <= val_m[cur_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      head_q <= Nil;
      tail_q <= Nil;
      cur_q <= Nil;
      cnt_q <= '0;
      ok_q <= 1'b0;
      req_q <= '0;
      ival_q <= '0;
      d_q <= '0;
      p_q <= '0;
      n_q <= '0;
      lp_q <= '0;
      ln_q <= '0;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (req_valid_i) begin
            req_q <= req_type_i;
            ival_q <= VALUE_BITS'(item_value_i);
            ok_q <= 1'b0;
            st_q <= StRdA;
          end
        end
        StRdA: begin
          st_q <= StFin;
          if (req_q == ReqInsert) begin
            if (cnt_q != Nil) begin
              p_q <= (cur_q == Nil) ? tail_q : prv_m[cur_q[IW-1:0]];
              st_q <= StWrA;
            end
          end else if (req_q == ReqRemove) begin
            if (cnt_q != '0) begin
              d_q <= (cur_q == Nil) ? tail_q : cur_q;
              st_q <= StRmP;
            end
          end else if (req_q == ReqRewind) begin
            cur_q <= head_q;
            ok_q <= (head_q != Nil);
          end else if (req_q == ReqAdvance) begin
            if (cur_q != Nil) cur_q <= nxt_m[cur_q[IW-1:0]];
          end else if (req_q == ReqRead) begin
            ok_q <= (cur_q != Nil);
          end
        end
        StWrA: st_q <= StWrB;
        StWrB: begin
          if (p_q == Nil) head_q <= cnt_q;
          if (cur_q == Nil) tail_q <= cnt_q;
          cnt_q <= cnt_q + LW'(1);
          ok_q <= 1'b1;
          st_q <= StFin;
        end
        StRmP: begin
          p_q <= prv_m[d_q[IW-1:0]];
          n_q <= nxt_m[d_q[IW-1:0]];
          st_q <= StRmN;
        end
        StRmN: begin
          if (p_q == Nil) head_q <= n_q;
          if (n_q == Nil) tail_q <= p_q;
          cur_q <= (n_q != Nil) ? n_q : p_q;
          st_q <= StRmL;
        end
        StRmL: begin
          lp_q <= prv_m[last[IW-1:0]];
          ln_q <= nxt_m[last[IW-1:0]];
          if (d_q != last) st_q <= StMvV;
          else st_q <= StMvN;
        end
        StMvV: begin
          // Link fields of the moved entry may be refreshed by the unlink.
          if (lp_q == d_q) lp_q <= p_q;
          if (ln_q == d_q) ln_q <= n_q;
          st_q <= StMvP;
          if (lp_q == d_q || ln_q == d_q) st_q <= StMvV;
        end
        StMvP: begin
          if (lp_q == Nil) head_q <= d_q;
          if (ln_q == Nil) tail_q <= d_q;
          if (cur_q == last) cur_q <= d_q;
          st_q <= StMvN;
        end
        StMvN: begin
          cnt_q <= last;
          ok_q <= 1'b1;
          st_q <= StFin;
        end
        StFin: begin
          if (req_q == ReqAdvance) ok_q <= (cur_q != Nil);
          st_q <= StFinV;
        end
        StFinV: st_q <= StOut;
        StOut: if (!res_stall_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
